// ----- design/rsa_pkg.sv -----
// Shared constants and types for the RSA byte encrypt/decrypt block.
package rsa_pkg;
    localparam int MOD_BITS_DEFAULT = 32;
    localparam int REG_W = 32;
    localparam int CHAR_W = 8;
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_PUB_EXP = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRIV_EXP = 2'd2;
    localparam logic [REG_W-1:0] MODULUS_RESET = 32'd3;
    localparam logic [REG_W-1:0] EXP_RESET = 32'd1;
endpackage

// ----- design/rsa_modexp.sv -----
// Iterative modular exponentiation built on a shared modular adder and doubler.
module rsa_modexp #(
    parameter int MOD_BITS = rsa_pkg::MOD_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [MOD_BITS-1:0]     base,
    input  logic [rsa_pkg::REG_W-1:0] exponent,
    input  logic [MOD_BITS-1:0]     modulus,
    output logic                    done,
    output logic [MOD_BITS-1:0]     result
);
    typedef enum logic [2:0] {S_IDLE, S_REDUCE, S_EXP, S_MUL, S_DONE} state_t;

    state_t                    state_reg;
    logic [MOD_BITS-1:0]       res_reg, sq_reg, acc_reg, addend_reg, mul_b_reg;
    logic [rsa_pkg::REG_W-1:0] k_reg;
    logic                      mul_is_sq_reg;
    logic [MOD_BITS:0]         rbase_reg;

    // Shared modular adder: (a + b) mod n for a, b < n.
    function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] a,
        input logic [MOD_BITS-1:0] b, input logic [MOD_BITS-1:0] n);
        logic [MOD_BITS-1:0] room;
        room = n - b;
        add_mod = (a >= room) ? (a - room) : (a + b);
    endfunction

    logic [MOD_BITS-1:0] sum_a, sum_b, sum_out;
    always_comb begin
        sum_a = acc_reg;
        sum_b = addend_reg;
        if (mul_b_reg[0] == 1'b0) begin
            sum_a = addend_reg;
        end
        sum_out = add_mod(sum_a, sum_b, modulus);
    end

    assign done = (state_reg == S_DONE);
    assign result = res_reg;

    // Sequencer: the base is reduced with one compare-subtract per cycle, then
    // square-and-multiply runs one shift-and-add step per cycle. A new start
    // is taken while idle or in the cycle that presents the previous result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE, S_DONE: begin
                    if (start) begin
                        rbase_reg <= {1'b0, base};
                        k_reg <= exponent;
                        res_reg <= (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                        state_reg <= S_REDUCE;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_REDUCE: begin
                    if (rbase_reg >= {1'b0, modulus}) begin
                        rbase_reg <= rbase_reg - {1'b0, modulus};
                    end else begin
                        sq_reg <= rbase_reg[MOD_BITS-1:0];
                        state_reg <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (k_reg == '0) begin
                        state_reg <= S_DONE;
                    end else begin
                        acc_reg <= '0;
                        addend_reg <= sq_reg;
                        mul_is_sq_reg <= ~k_reg[0];
                        mul_b_reg <= k_reg[0] ? res_reg : sq_reg;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_b_reg == '0) begin
                        if (mul_is_sq_reg) begin
                            sq_reg <= acc_reg;
                            k_reg <= k_reg >> 1;
                            state_reg <= S_EXP;
                        end else begin
                            res_reg <= acc_reg;
                            acc_reg <= '0;
                            addend_reg <= sq_reg;
                            mul_b_reg <= sq_reg;
                            mul_is_sq_reg <= 1'b1;
                        end
                    end else begin
                        if (mul_b_reg[0]) begin
                            acc_reg <= sum_out;
                            addend_reg <= add_mod(addend_reg, addend_reg, modulus);
                        end else begin
                            addend_reg <= sum_out;
                        end
                        mul_b_reg <= mul_b_reg >> 1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/rsa_char_encrypt_decrypt_top.sv -----
// Top level of the RSA byte encrypt/decrypt block.
// Usage: write the modulus (index 0), public exponent (1) and private
// exponent (2) on the cfg channel while the block is idle. Each input item
// is one byte on s_plain_char. The block returns one item holding
// m^e mod n on m_cipher_value and (m^e)^d mod n on m_recovered_value.
// Only the low MOD_BITS bits of the modulus are used; modulus zero gives
// zero results.
// The two exponentiations run in series on one modular exponent unit.
// Each multiply steps once per significant bit of its multiplier, and the
// byte is reduced by repeated subtraction of the modulus.
// s_ready is low from acceptance until the result is taken. A stalled
// m_ready just holds the result register.
// Reset sets modulus 3 and both exponents to 1 and clears the control.
module rsa_char_encrypt_decrypt_top #(
    parameter int MOD_BITS = rsa_pkg::MOD_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rsa_pkg::CHAR_W-1:0]     s_plain_char,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rsa_pkg::REG_W-1:0]      m_cipher_value,
    output logic [rsa_pkg::REG_W-1:0]      m_recovered_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsa_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rsa_pkg::REG_W-1:0]      cfg_data
);
    typedef enum logic [2:0] {T_IDLE, T_ENC, T_DEC, T_OUT} state_t;

    state_t                    state_reg;
    logic [rsa_pkg::REG_W-1:0] modulus_reg, pub_reg, priv_reg;
    logic [rsa_pkg::REG_W-1:0] cipher_reg, recov_reg;
    logic                      start;
    logic [MOD_BITS-1:0]       base, n_eff, ex_result;
    logic [rsa_pkg::REG_W-1:0] exponent;
    logic                      ex_done;
    logic [MOD_BITS-1:0]       char_ext;

    // Effective modulus: low MOD_BITS bits of the register.
    always_comb begin
        n_eff = MOD_BITS'(modulus_reg);
        char_ext = MOD_BITS'(s_plain_char);
    end

    assign s_ready = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid = (state_reg == T_OUT);
    assign m_cipher_value = cipher_reg;
    assign m_recovered_value = recov_reg;

    // Start the unit on accept with a nonzero modulus (encrypt) and after encryption (decrypt).
    assign start = (state_reg == T_IDLE && s_valid && n_eff != '0) ||
                   (state_reg == T_ENC && ex_done);
    assign base = (state_reg == T_IDLE) ? char_ext : ex_result;
    assign exponent = (state_reg == T_IDLE) ? pub_reg : priv_reg;

    rsa_modexp #(.MOD_BITS(MOD_BITS)) u_modexp (
        .aclk(aclk), .aresetn(aresetn), .start(start), .base(base),
        .exponent(exponent), .modulus(n_eff), .done(ex_done), .result(ex_result)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= rsa_pkg::MODULUS_RESET;
            pub_reg <= rsa_pkg::EXP_RESET;
            priv_reg <= rsa_pkg::EXP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                rsa_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                rsa_pkg::REG_PUB_EXP: pub_reg <= cfg_data;
                rsa_pkg::REG_PRIV_EXP: priv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            case (state_reg)
                T_IDLE: begin
                    if (s_valid) begin
                        if (n_eff == '0) begin
                            cipher_reg <= '0;
                            recov_reg <= '0;
                            state_reg <= T_OUT;
                        end else begin
                            state_reg <= T_ENC;
                        end
                    end
                end
                T_ENC: begin
                    if (ex_done) begin
                        cipher_reg <= rsa_pkg::REG_W'(ex_result);
                        state_reg <= T_DEC;
                    end
                end
                T_DEC: begin
                    if (ex_done) begin
                        recov_reg <= rsa_pkg::REG_W'(ex_result);
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (m_ready) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end
endmodule

// ----- design/rsa_checker.sv -----
// Port-level checker for the RSA byte encrypt/decrypt block.
module rsa_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic [31:0] m_cipher_value
);
    // No new item is taken while a result waits.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while result pending");
    // A result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cipher_value))
        else $error("result dropped or changed");
    // Input ready drops in the cycle after an item is accepted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");
    // After a result is taken the block is ready again.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready) else $error("not ready after output");
endmodule

bind rsa_char_encrypt_decrypt_top rsa_checker u_rsa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_cipher_value(m_cipher_value)
);
